// ===== rtl/core/fcf_pkg.sv =====
package fcf_pkg;

   localparam int NCOEF    = 7;
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int RESULT_W = 34;
   localparam int TAP_W    = 3;
   localparam int REG_W    = 32;
   localparam int ADDR_W   = 5;
   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   typedef enum logic [TAP_W-1:0] {
      REG_TAP_COUNT = 3'd0,
      REG_COEF_0    = 3'd1,
      REG_COEF_1    = 3'd2,
      REG_COEF_2    = 3'd3,
      REG_COEF_3    = 3'd4,
      REG_COEF_4    = 3'd5,
      REG_COEF_5    = 3'd6,
      REG_COEF_6    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                end_of_signal;
   } item_type;

   typedef struct packed {
      logic [TAP_W-1:0]                tap_count;
      logic [NCOEF-1:0][COEF_W-1:0]    coef;
   } cfg_type;

endpackage

// ===== rtl/core/fcf_ifs.sv =====
interface fcf_req_if
   import fcf_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                end_of_signal;

   modport source (output valid, output sample, output end_of_signal, input ready);
   modport sink (input valid, input sample, input end_of_signal, output ready);
endinterface

interface fcf_rsp_if
   import fcf_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [RESULT_W-1:0] result;
   logic                last_out;

   modport source (output valid, output result, output last_out, input ready);
   modport sink (input valid, input result, input last_out, output ready);
endinterface

// ===== rtl/core/fcf_regs.sv =====
module fcf_regs
   import fcf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [REG_W-1:0]  pwdata,
   output logic [REG_W-1:0]  prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [TAP_W-1:0]  tap_count_ff;
   logic [COEF_W-1:0] coef_ff [NCOEF];
   reg_index_type     idx;
   logic              wr_en;
   logic [TAP_W-1:0]  coef_sel;

   assign idx      = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en    = psel & penable & pwrite;
   assign pready   = 1'b1;
   assign coef_sel = paddr[ADDR_W-1:2] - TAP_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_W'(1);
         for (int k = 1; k < NCOEF; k++) begin
            coef_ff[k] <= '0;
         end
         coef_ff[0] <= COEF_W'(32767);
      end else if (wr_en) begin
         case (idx)
            REG_TAP_COUNT: begin
               tap_count_ff <= pwdata[TAP_W-1:0];
            end
            default: begin
               coef_ff[coef_sel] <= pwdata[COEF_W-1:0];
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_TAP_COUNT: begin
            prdata = {{(REG_W-TAP_W){1'b0}}, tap_count_ff};
         end
         default: begin
            prdata = {{(REG_W-COEF_W){coef_ff[coef_sel][COEF_W-1]}}, coef_ff[coef_sel]};
         end
      endcase
   end

   always_comb begin
      cfg.tap_count = tap_count_ff;
      for (int k = 0; k < NCOEF; k++) begin
         cfg.coef[k] = coef_ff[k];
      end
   end

endmodule

// ===== rtl/core/fcf_front.sv =====
module fcf_front
   import fcf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   fcf_req_if.sink    req,
   input  logic       q_pop,
   output logic       q_valid,
   output item_type   q_item
);

   item_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              push;
   logic              pop;

   assign req.ready = (count_ff != QCNT_W'(QDEPTH));
   assign push      = req.valid & req.ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop & q_valid;
   assign q_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{sample: req.sample, end_of_signal: req.end_of_signal};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue count lost a push");

endmodule

// ===== rtl/core/fcf_back.sv =====
module fcf_back
   import fcf_pkg::*;
#(
   parameter int TAPS = 7
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   fcf_rsp_if.source  rsp
);

   localparam int NPAIR = (TAPS + 1) / 2;

   logic [TAP_W-1:0]                taps;
   logic                            en;
   logic                            fire;
   logic [TAPS-1:0][SAMPLE_W-1:0]   g_win;
   logic                            g_last;

   logic [TAPS-1:0][SAMPLE_W-1:0]   dl_ff;
   logic [TAPS-1:0][SAMPLE_W-1:0]   dl_in;
   logic                            tail_ff;
   logic                            tail_in;
   logic [TAP_W-1:0]                tail_cnt_ff;
   logic [TAP_W-1:0]                tail_cnt_in;

   logic                            w_valid_ff;
   logic                            w_last_ff;
   logic [TAPS-1:0][SAMPLE_W-1:0]   w_win_ff;

   logic                            m_valid_ff;
   logic                            m_last_ff;
   logic signed [PROD_W-1:0]        m_prod_ff [TAPS];
   logic signed [PROD_W-1:0]        m_prod_in [TAPS];

   logic                            a_valid_ff;
   logic                            a_last_ff;
   logic signed [PROD_W:0]          a_sum_ff [NPAIR];
   logic signed [PROD_W:0]          a_sum_in [NPAIR];

   logic                            o_valid_ff;
   logic                            o_last_ff;
   logic signed [RESULT_W-1:0]      o_result_ff;
   logic signed [RESULT_W-1:0]      o_result_in;

   always_comb begin
      if (cfg.tap_count == '0) begin
         taps = TAP_W'(1);
      end else if (cfg.tap_count > TAP_W'(TAPS)) begin
         taps = TAP_W'(TAPS);
      end else begin
         taps = cfg.tap_count;
      end
   end

   assign en    = !o_valid_ff || rsp.ready;
   assign q_pop = en && !tail_ff && q_valid;
   assign fire  = en && (tail_ff || q_valid);

   always_comb begin
      g_win = '0;
      if (tail_ff) begin
         g_win[0] = '0;
         g_last   = (tail_cnt_ff == TAP_W'(1));
      end else begin
         g_win[0] = q_item.sample;
         g_last   = q_item.end_of_signal && (taps == TAP_W'(1));
      end
      for (int k = 1; k < TAPS; k++) begin
         g_win[k] = dl_ff[k-1];
      end
   end

   always_comb begin
      dl_in       = dl_ff;
      tail_in     = tail_ff;
      tail_cnt_in = tail_cnt_ff;
      if (fire) begin
         if (g_last) begin
            dl_in       = '0;
            tail_in     = 1'b0;
            tail_cnt_in = '0;
         end else if (tail_ff) begin
            dl_in       = g_win;
            tail_cnt_in = tail_cnt_ff - TAP_W'(1);
         end else if (q_item.end_of_signal) begin
            dl_in       = g_win;
            tail_in     = 1'b1;
            tail_cnt_in = taps - TAP_W'(1);
         end else begin
            dl_in = g_win;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         if (TAP_W'(k) < taps) begin
            m_prod_in[k] = $signed(w_win_ff[k]) * $signed(cfg.coef[k]);
         end else begin
            m_prod_in[k] = '0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NPAIR; i++) begin
         a_sum_in[i] = {m_prod_ff[2*i][PROD_W-1], m_prod_ff[2*i]};
         if (2*i + 1 < TAPS) begin
            a_sum_in[i] = a_sum_in[i] + {m_prod_ff[2*i+1][PROD_W-1], m_prod_ff[2*i+1]};
         end
      end
   end

   always_comb begin
      o_result_in = '0;
      for (int i = 0; i < NPAIR; i++) begin
         o_result_in = o_result_in + RESULT_W'(a_sum_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_win_ff    <= g_win;
         w_last_ff   <= g_last;
         m_prod_ff   <= m_prod_in;
         m_last_ff   <= w_last_ff;
         a_sum_ff    <= a_sum_in;
         a_last_ff   <= m_last_ff;
         o_result_ff <= o_result_in;
         o_last_ff   <= a_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff       <= '0;
         tail_ff     <= 1'b0;
         tail_cnt_ff <= '0;
         w_valid_ff  <= 1'b0;
         m_valid_ff  <= 1'b0;
         a_valid_ff  <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         dl_ff       <= dl_in;
         tail_ff     <= tail_in;
         tail_cnt_ff <= tail_cnt_in;
         if (en) begin
            w_valid_ff <= fire;
            m_valid_ff <= w_valid_ff;
            a_valid_ff <= m_valid_ff;
            o_valid_ff <= a_valid_ff;
         end
      end
   end

   assign rsp.valid    = o_valid_ff;
   assign rsp.result   = o_result_ff;
   assign rsp.last_out = o_last_ff;

   a_tail_cnt: assert property (@(posedge clock) disable iff (reset)
      tail_ff |-> tail_cnt_ff != '0)
      else $error("tail mode with zero count");

   a_no_pop_in_tail: assert property (@(posedge clock) disable iff (reset)
      tail_ff |-> !q_pop)
      else $error("queue popped during tail flush");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (fire && g_last) |=> (dl_ff == '0) && !tail_ff)
      else $error("delay line not cleared after last transaction");

   a_tail_start: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_item.end_of_signal && !g_last) |=>
         tail_ff && (tail_cnt_ff == $past(taps) - TAP_W'(1)))
      else $error("tail flush not started");

endmodule

// ===== rtl/core/full_linear_convolution_fir.sv =====
// An accepted req transaction passes the queue, window, multiply and
// pair-add registers, then the final add into the output register.
// Throughput: one rsp transaction per cycle unless rsp_ch stalls; a sample
// marked end_of_signal is flushed out with zeros (tail flush) if taps > 1.
// Reset (synchronous): queue and pipeline empty, delay line zero,
// tap_count = 1, coef_0 = 32767, other coefficients 0.
module full_linear_convolution_fir
   import fcf_pkg::*;
#(
   parameter int TAPS = 7
) (
   input  logic              clock,
   input  logic              reset,
   fcf_req_if.sink           req_ch,
   fcf_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [REG_W-1:0]  pwdata,
   output logic [REG_W-1:0]  prdata,
   output logic              pready
);

   cfg_type  cfg;
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   fcf_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fcf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_item  (q_item)
   );

   fcf_back #(
      .TAPS (TAPS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule
